/* sv/gqr_pkg.sv */
package gqr_pkg;

    // Ring geometry
    localparam int CAPACITY    = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int PTR_W       = IDX_W + 1;
    localparam int FLUSH_LIMIT = 32;
    localparam int EPOCH_GAP   = 2;
    localparam int QUEUE_DEPTH = 2;

    // Field widths
    localparam int ADDR_W  = 48;
    localparam int SIZE_W  = 32;
    localparam int EPOCH_W = 32;
    localparam int TAG_W   = 16;
    localparam int CNT_W   = 6;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = ADDR_W + SIZE_W + EPOCH_W + TAG_W;

    // Stream widths
    localparam int S_DATA_W = 168;
    localparam int M_DATA_W = 112;

    // Input beat layout, lowest bit up
    localparam int S_ADDR_LO  = 0;
    localparam int S_SIZE_LO  = S_ADDR_LO + ADDR_W;
    localparam int S_EPOCH_LO = S_SIZE_LO + SIZE_W;
    localparam int S_TAG_LO   = S_EPOCH_LO + EPOCH_W;
    localparam int S_MAX_LO   = S_TAG_LO + TAG_W;
    localparam int S_FORCE_LO = S_MAX_LO + CNT_W;
    localparam int S_NOW_LO   = S_FORCE_LO + 1;

    // Result beat layout, lowest bit up
    localparam int M_STAT_LO = 0;
    localparam int M_ADDR_LO = M_STAT_LO + STAT_W;
    localparam int M_SIZE_LO = M_ADDR_LO + ADDR_W;
    localparam int M_TAG_LO  = M_SIZE_LO + SIZE_W;
    localparam int M_CNT_LO  = M_TAG_LO + TAG_W;
    localparam int M_OCC_LO  = M_CNT_LO + CNT_W;
    localparam int M_USED_W  = M_OCC_LO + CNT_W;

    // Item kinds
    localparam logic FUNC_ENQUEUE = 1'b0;
    localparam logic FUNC_FLUSH   = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ENQ     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RETIRED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd2;

    // Enqueue status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SAT  = 2'd2;

    // Classified command passed from front to back
    typedef struct packed {
        logic               func;
        logic               addr_zero;
        logic [ADDR_W-1:0]  addr;
        logic [SIZE_W-1:0]  size;
        logic [EPOCH_W-1:0] epoch;
        logic [TAG_W-1:0]   tag;
        logic [CNT_W-1:0]   limit;
        logic               force_req;
        logic [EPOCH_W-1:0] now;
    } cmd_t;

    // One result beat
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [STAT_W-1:0]  status;
        logic [ADDR_W-1:0]  addr;
        logic [SIZE_W-1:0]  size;
        logic [TAG_W-1:0]   tag;
        logic [CNT_W-1:0]   count;
        logic [CNT_W-1:0]   occ;
        logic               last;
    } res_t;

    // Handshake between queue and back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } qout_t;

endpackage

/* sv/gqr_ram.sv */
module gqr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/gqr_queue.sv */
module gqr_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  gqr_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output gqr_pkg::qout_t head
);
    import gqr_pkg::*;

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push_ok, pop_ok;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push_ok = push && !full;
    assign pop_ok  = pop && (count_reg != '0);

    // Advance pointers, wrapping at the queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            count_next = count_reg + 1'b1;
        end else if (pop_ok && !push_ok) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload, no reset needed
    always_ff @(posedge aclk) begin
        if (push_ok) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

endmodule

/* sv/gqr_front.sv */
module gqr_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gqr_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,
    input  logic                          cmd_pop,
    output gqr_pkg::qout_t                cmd_head
);
    import gqr_pkg::*;

    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic cmd_valid_reg;
    logic q_full;
    logic push_ok;
    logic [CNT_W-1:0] raw_max;

    // Classify the incoming beat: flag zero address, clamp the retire limit
    always_comb begin
        raw_max            = s_tdata[S_MAX_LO +: CNT_W];
        cmd_next.func      = s_tuser;
        cmd_next.addr      = s_tdata[S_ADDR_LO +: ADDR_W];
        cmd_next.addr_zero = (s_tdata[S_ADDR_LO +: ADDR_W] == '0);
        cmd_next.size      = s_tdata[S_SIZE_LO +: SIZE_W];
        cmd_next.epoch     = s_tdata[S_EPOCH_LO +: EPOCH_W];
        cmd_next.tag       = s_tdata[S_TAG_LO +: TAG_W];
        cmd_next.limit     = (raw_max > CNT_W'(FLUSH_LIMIT)) ? CNT_W'(FLUSH_LIMIT) : raw_max;
        cmd_next.force_req = s_tdata[S_FORCE_LO];
        cmd_next.now       = s_tdata[S_NOW_LO +: EPOCH_W];
    end

    assign push_ok  = cmd_valid_reg && !q_full;
    assign s_tready = !cmd_valid_reg || !q_full;

    // Hold the classified command until the queue takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            cmd_valid_reg <= 1'b1;
        end else if (push_ok) begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg <= cmd_next;
        end
    end

    gqr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_valid_reg),
        .push_cmd (cmd_reg),
        .full     (q_full),
        .pop      (cmd_pop),
        .head     (cmd_head)
    );

endmodule

/* sv/gqr_back.sv */
module gqr_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  gqr_pkg::qout_t cmd_head,
    output logic           cmd_pop,
    output logic           res_valid,
    input  logic           res_ready,
    output gqr_pkg::res_t  res
);
    import gqr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } state_t;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   done_reg, done_next;
    logic [CNT_W-1:0]   limit_reg, limit_next;
    logic               force_reg, force_next;
    logic [EPOCH_W-1:0] now_reg, now_next;
    logic               out_valid_reg, out_valid_next;
    res_t               res_reg, res_next;

    logic               full, empty, out_free, wait_epoch;
    logic               wr_en, rd_en;
    logic [ENTRY_W-1:0] wr_data, rd_data;
    logic [ADDR_W-1:0]  rd_addr_f;
    logic [SIZE_W-1:0]  rd_size_f;
    logic [EPOCH_W-1:0] rd_epoch_f;
    logic [TAG_W-1:0]   rd_tag_f;
    cmd_t               cmd;

    assign cmd      = cmd_head.cmd;
    assign empty    = (tail_reg == head_reg);
    assign full     = (tail_reg[IDX_W] != head_reg[IDX_W])
                   && (tail_reg[IDX_W-1:0] == head_reg[IDX_W-1:0]);
    assign out_free = !out_valid_reg || res_ready;

    assign wr_data = {cmd.tag, cmd.epoch, cmd.size, cmd.addr};
    assign {rd_tag_f, rd_epoch_f, rd_size_f, rd_addr_f} = rd_data;

    // Entry waits while its epoch plus the gap is beyond the current epoch
    assign wait_epoch = !force_reg
        && (({1'b0, rd_epoch_f} + (EPOCH_W + 1)'(EPOCH_GAP)) > {1'b0, now_reg});

    gqr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (head_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Sequence enqueues and the flush retire loop
    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        done_next      = done_reg;
        limit_next     = limit_reg;
        force_next     = force_reg;
        now_next       = now_reg;
        out_valid_next = out_valid_reg && !res_ready;
        res_next       = res_reg;
        cmd_pop        = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_head.valid && out_free) begin
                    cmd_pop = 1'b1;
                    if (cmd.func == FUNC_ENQUEUE) begin
                        res_next        = '0;
                        res_next.kind   = KIND_ENQ;
                        res_next.last   = 1'b1;
                        if (cmd.addr_zero) begin
                            res_next.status = STAT_ZERO;
                        end else if (full) begin
                            res_next.status = STAT_SAT;
                        end else begin
                            res_next.status = STAT_OK;
                            wr_en           = 1'b1;
                            tail_next       = tail_reg + 1'b1;
                        end
                        res_next.occ   = CNT_W'(tail_next - head_reg);
                        out_valid_next = 1'b1;
                    end else begin
                        limit_next = cmd.limit;
                        force_next = cmd.force_req;
                        now_next   = cmd.now;
                        done_next  = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (empty || done_reg == limit_reg) begin
                    if (out_free) begin
                        res_next       = '0;
                        res_next.kind  = KIND_DONE;
                        res_next.count = done_reg;
                        res_next.occ   = CNT_W'(tail_reg - head_reg);
                        res_next.last  = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (out_free) begin
                    res_next       = '0;
                    out_valid_next = 1'b1;
                    if (wait_epoch) begin
                        res_next.kind  = KIND_DONE;
                        res_next.count = done_reg;
                        res_next.occ   = CNT_W'(tail_reg - head_reg);
                        res_next.last  = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        head_next     = head_reg + 1'b1;
                        done_next     = done_reg + 1'b1;
                        res_next.kind = KIND_RETIRED;
                        res_next.addr = rd_addr_f;
                        res_next.size = rd_size_f;
                        res_next.tag  = rd_tag_f;
                        res_next.occ  = CNT_W'(tail_reg - head_next);
                        state_next    = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, pointers and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
        limit_reg <= limit_next;
        force_reg <= force_next;
        now_reg   <= now_next;
        res_reg   <= res_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    // Ring never holds more than its capacity
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (PTR_W'(tail_reg - head_reg) <= PTR_W'(CAPACITY)))
        else $error("ring occupancy above capacity");

    // No slot is written while the ring is full
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !full)
        else $error("slot written while ring full");

    // No slot is read while the ring is empty
    a_no_empty_read: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> !empty)
        else $error("slot read while ring empty");

    // A flush never retires more than its limit
    a_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (done_reg <= limit_reg))
        else $error("flush retired past its limit");

    // Evaluation always follows a slot read
    a_eval_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL && $past(state_reg) != ST_EVAL) |-> $past(rd_en))
        else $error("entry evaluated without a read");

endmodule

/* sv/epoch_gated_quarantine_ring.sv */
// Quarantine ring for freed blocks, 32 slots.
// Input stream (s_*): one beat per command. s_tuser selects enqueue (0) or
// flush (1). An enqueue stores address, size, free epoch and owner tag at the
// tail and answers with one status beat. A flush retires entries from the head
// while their epoch plus two is not beyond the current epoch (or always when
// forced), up to max_count, giving one beat per retired entry and a closing
// beat with the count. The closing or status beat carries m_tlast.
// Every result beat reports ring occupancy after it.
// Path: an enqueue's status beat follows its input beat through the input
// register, the command queue and the result register; a flush's first
// beat also waits for the slot read.
// Throughput: enqueues sustain one per cycle while m_tready is high. A flush
// retires its entries one after another, each in a read state and an
// evaluate state, since each entry needs a read of the slot memory, whose
// registered read port is followed by the epoch check.
// Reset: synchronous, active low; empties the ring and drops queued commands.
// Stall: while m_tready is low the result beat holds; the back end stops, the
// two-entry command queue and the input register fill, then s_tready falls.
module epoch_gated_quarantine_ring (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: block_addr[47:0], block_size[79:48], entry_epoch[111:80],
    //        owner_tag[127:112], max_count[133:128], force_req[134],
    //        current_epoch[166:135], zero pad[167]
    input  logic [gqr_pkg::S_DATA_W-1:0]  s_tdata,
    // tuser: func[0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: status[1:0], retired_addr[49:2], retired_size[81:50],
    //        retired_tag[97:82], flushed_count[103:98], occupancy[109:104],
    //        zero pad[111:110]
    output logic [gqr_pkg::M_DATA_W-1:0]  m_tdata,
    // tuser: kind[1:0]
    output logic [gqr_pkg::KIND_W-1:0]    m_tuser,
    output logic                          m_tlast
);
    import gqr_pkg::*;

    qout_t cmd_head;
    logic  cmd_pop;
    res_t  res;

    gqr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd_pop  (cmd_pop),
        .cmd_head (cmd_head)
    );

    gqr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result beat
    assign m_tdata = {(M_DATA_W - M_USED_W)'(0), res.occ, res.count, res.tag,
                      res.size, res.addr, res.status};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule
